>>> sv/ppcc_pkg.sv
// ----------------------------------------------------------------------------
// Power cycle controller package
// Widths, register indexes and reset values shared by the controller.
// ----------------------------------------------------------------------------
package ppcc_pkg;

    localparam int SECONDS_WIDTH = 20;
    localparam int OUT_SEC_W     = 20;
    localparam int TPS_W         = 4;
    localparam int CFG_DATA_W    = 20;
    localparam int CFG_ADDR_W    = 3;
    localparam int STATE_W       = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_SECOND  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_OFF       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD            = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARN              = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHUTDOWN_HOLD     = 3'd4;

    localparam logic [TPS_W-1:0]      RST_TICKS_PER_SECOND  = 4'd5;
    localparam logic [CFG_DATA_W-1:0] RST_INITIAL_OFF       = 20'd10;
    localparam logic [CFG_DATA_W-1:0] RST_PERIOD            = 20'd86400;
    localparam logic [CFG_DATA_W-1:0] RST_WARN              = 20'd60;
    localparam logic [CFG_DATA_W-1:0] RST_SHUTDOWN_HOLD     = 20'd60;

endpackage

>>> sv/periodic_power_cycle_controller_unit.sv
// ----------------------------------------------------------------------------
// Periodic power cycle controller
// Counts timer ticks into seconds and steps a power switching state machine,
// sensing button presses on the shared LED pin. One result per tick.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction  Carries
//  s_        s_valid s_ready s_pin_low               in         one tick request
//  m_        m_valid m_ready m_gate_on m_led_drive   out        one result per tick
//            m_state_code m_elapsed_seconds
//  cfg_      cfg_wr_en cfg_addr cfg_wdata            in         register writes
//
//  An accepted request waits in the input register until its result moves
//  to the result register. One request is accepted every cycle unless a
//  result is stalled; the state update is combinational between the two.
//  Reset is synchronous on aresetn and clears all control state.
//  A stalled result holds the pipeline; s_ready drops only when both stages
//  are full and m_ready is low.
module periodic_power_cycle_controller_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_pin_low,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_gate_on,
    output logic                               m_led_drive,
    output logic [ppcc_pkg::STATE_W-1:0]       m_state_code,
    output logic [ppcc_pkg::OUT_SEC_W-1:0]     m_elapsed_seconds,
    input  logic                               cfg_wr_en,
    input  logic [ppcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ppcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ppcc_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        ST_INIT_OFF      = 3'd0,
        ST_ON            = 3'd1,
        ST_WARN          = 3'd2,
        ST_WAIT_SHUTDOWN = 3'd3,
        ST_SHUTDOWN_HOLD = 3'd4,
        ST_WAIT_POWERUP  = 3'd5
    } state_t;

    localparam logic [SECONDS_WIDTH-1:0] SEC_MAX = '1;

    logic [TPS_W-1:0]         tps_reg;
    logic [CFG_DATA_W-1:0]    initial_off_reg;
    logic [CFG_DATA_W-1:0]    period_reg;
    logic [CFG_DATA_W-1:0]    warn_reg;
    logic [CFG_DATA_W-1:0]    hold_reg;

    logic                     in_valid_reg;
    logic                     in_pin_reg;
    logic                     advance;

    state_t                   state_reg, state_next;
    logic [TPS_W-1:0]         presc_reg, presc_next;
    logic [SECONDS_WIDTH-1:0] cnt_reg, cnt_next;
    logic [SECONDS_WIDTH-1:0] mark_reg, mark_next;
    logic                     pend_reg, pend_next;

    logic                     out_valid_reg;
    logic                     out_gate_reg, out_gate_next;
    logic                     out_led_reg, out_led_next;
    logic [STATE_W-1:0]       out_state_reg;
    logic [OUT_SEC_W-1:0]     out_sec_reg;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        logic [TPS_W-1:0]         p_inc;
        logic [CFG_DATA_W-1:0]    warn_at;
        logic [SECONDS_WIDTH-1:0] since;
        state_t                   cur;

        p_inc      = presc_reg + 1'b1;
        presc_next = p_inc;
        cnt_next   = cnt_reg;
        mark_next  = mark_reg;
        pend_next  = pend_reg;
        cur        = state_reg;

        if (p_inc >= tps_reg || p_inc == '0) begin
            presc_next = '0;
            if (cnt_reg != SEC_MAX) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (!cnt_next[0] && in_pin_reg && (cur == ST_ON || cur == ST_WAIT_POWERUP)) begin
            pend_next = 1'b1;
        end

        warn_at = (period_reg > warn_reg) ? (period_reg - warn_reg) : '0;

        if (cur == ST_INIT_OFF) begin
            if (cnt_next >= SECONDS_WIDTH'(initial_off_reg)) begin
                cur = ST_ON;
            end
        end
        if (cur == ST_ON) begin
            if (cnt_next >= SECONDS_WIDTH'(warn_at)) begin
                cur = ST_WARN;
            end
            if (pend_next) begin
                pend_next = 1'b0;
                cur       = ST_WAIT_SHUTDOWN;
                mark_next = cnt_next;
            end
        end
        if (cur == ST_WARN) begin
            if (cnt_next >= SECONDS_WIDTH'(period_reg)) begin
                cur      = ST_INIT_OFF;
                cnt_next = '0;
            end
        end
        since = cnt_next - mark_next;
        if (cur == ST_WAIT_SHUTDOWN) begin
            if (since >= SECONDS_WIDTH'(warn_reg)) begin
                cur       = ST_SHUTDOWN_HOLD;
                mark_next = cnt_next;
            end
        end
        since = cnt_next - mark_next;
        if (cur == ST_SHUTDOWN_HOLD) begin
            if (since >= SECONDS_WIDTH'(hold_reg)) begin
                cur = ST_WAIT_POWERUP;
            end
        end
        if (cur == ST_WAIT_POWERUP) begin
            if (pend_next) begin
                pend_next = 1'b0;
                cur       = ST_INIT_OFF;
                cnt_next  = '0;
            end
        end

        state_next    = cur;
        out_gate_next = (cur == ST_ON || cur == ST_WARN || cur == ST_WAIT_SHUTDOWN);
        out_led_next  = (cur == ST_INIT_OFF || cur == ST_WARN || cur == ST_WAIT_SHUTDOWN)
                        ? 1'b1 : cnt_next[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg         <= RST_TICKS_PER_SECOND;
            initial_off_reg <= RST_INITIAL_OFF;
            period_reg      <= RST_PERIOD;
            warn_reg        <= RST_WARN;
            hold_reg        <= RST_SHUTDOWN_HOLD;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= ST_INIT_OFF;
            presc_reg       <= '0;
            cnt_reg         <= '0;
            mark_reg        <= '0;
            pend_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TICKS_PER_SECOND: begin
                        tps_reg <= cfg_wdata[TPS_W-1:0];
                    end
                    CFG_INITIAL_OFF: begin
                        initial_off_reg <= cfg_wdata;
                    end
                    CFG_PERIOD: begin
                        period_reg <= cfg_wdata;
                    end
                    CFG_WARN: begin
                        warn_reg <= cfg_wdata;
                    end
                    CFG_SHUTDOWN_HOLD: begin
                        hold_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                presc_reg     <= presc_next;
                cnt_reg       <= cnt_next;
                mark_reg      <= mark_next;
                pend_reg      <= pend_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_pin_reg <= s_pin_low;
        end
        if (advance) begin
            out_gate_reg  <= out_gate_next;
            out_led_reg   <= out_led_next;
            out_state_reg <= state_next;
            out_sec_reg   <= OUT_SEC_W'(cnt_next);
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_gate_on         = out_gate_reg;
    assign m_led_drive       = out_led_reg;
    assign m_state_code      = out_state_reg;
    assign m_elapsed_seconds = out_sec_reg;

    // A pending press is always consumed within the tick that latches it.
    assert property (@(posedge aclk) disable iff (!aresetn) !pend_reg)
        else $error("press left pending across ticks");

    // The seconds counter only holds, steps by one, or restarts at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (cnt_reg == '0 || cnt_reg == $past(cnt_reg) ||
                     cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("seconds counter jumped");

    // Power is applied only in on, warn and wait for shutdown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_gate_reg) |->
        (out_state_reg == ST_ON || out_state_reg == ST_WARN ||
         out_state_reg == ST_WAIT_SHUTDOWN))
        else $error("gate on in a powered-off state");

    // The LED is steady in the initial off state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_state_reg == ST_INIT_OFF) |-> out_led_reg)
        else $error("LED not lit in initial off state");

    // A result that is not taken keeps the pipeline from advancing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule
